// ===== rtl/ple_pkg.sv =====
`timescale 1ns / 1ps

package ple_pkg;

  localparam int DEPTH       = 16;
  localparam int ENTRY_WIDTH = 32;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  // common width for comparing a position against the count
  localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_READ   = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_BADPOS = 2'd1,
    STATUS_FULL   = 2'd2
  } status_e;

  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_cmd_t;

endpackage

// ===== rtl/ple_ctrl.sv =====
`timescale 1ns / 1ps

module ple_ctrl import ple_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output ctrl_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_RESP = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   in_acc;
  logic   out_acc;

  assign out_valid_o = (state_q == S_RESP);
  assign out_acc     = out_valid_o && !out_stall_i;
  // a new request may come in the cycle the pending result leaves
  assign in_stall_o  = !((state_q == S_IDLE) || out_acc);
  assign in_acc      = in_valid_i && !in_stall_o;

  assign cmd_o.load = in_acc;
  assign cmd_o.exec = (state_q == S_EXEC);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_RESP;
      end
      S_RESP: begin
        if (in_acc) state_d = S_EXEC;
        else if (out_acc) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/ple_datapath.sv =====
`timescale 1ns / 1ps

module ple_datapath import ple_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ctrl_cmd_t   cmd_i,
  input  logic [1:0]  mode_i,
  input  logic [4:0]  position_i,
  input  logic [31:0] entry_i,
  output logic [1:0]  status_o,
  output logic [31:0] read_entry_o,
  output logic [4:0]  count_o,
  output logic        empty_res_o,
  output logic        full_res_o
);

  logic [ENTRY_WIDTH-1:0] slots_q [DEPTH];
  logic [ENTRY_WIDTH-1:0] up_shift [DEPTH];
  logic [ENTRY_WIDTH-1:0] dn_shift [DEPTH];

  logic [CNT_W-1:0]       used_q, used_d;
  mode_e                  mode_q;
  logic [4:0]             pos_q;
  logic [ENTRY_WIDTH-1:0] entry_q;
  logic [63:0]            entry_wide;

  logic [CMP_W-1:0]       pos_ext, used_ext;
  logic [IDX_W-1:0]       pos_idx;
  logic                   ins_ok, rem_ok;
  status_e                status_d;
  logic [ENTRY_WIDTH-1:0] rd_d;
  logic [63:0]            rd_wide;
  logic [CMP_W-1:0]       cnt_wide;

  logic [1:0]             status_q;
  logic [31:0]            read_q;
  logic [4:0]             count_q;
  logic                   empty_q, full_q;

  assign entry_wide = 64'(entry_i);
  assign pos_ext    = CMP_W'(pos_q);
  assign used_ext   = CMP_W'(used_q);
  assign pos_idx    = pos_ext[IDX_W-1:0];

  always_comb begin
    ins_ok   = 1'b0;
    rem_ok   = 1'b0;
    status_d = STATUS_OK;
    rd_d     = '0;
    used_d   = used_q;
    unique case (mode_q)
      MODE_INSERT: begin
        if (pos_ext > used_ext) begin
          status_d = STATUS_BADPOS;
        end else if (used_q == CNT_W'(DEPTH)) begin
          status_d = STATUS_FULL;
        end else begin
          ins_ok = 1'b1;
          used_d = used_q + CNT_W'(1);
        end
      end
      MODE_REMOVE: begin
        if (pos_ext >= used_ext) begin
          status_d = STATUS_BADPOS;
        end else begin
          rem_ok = 1'b1;
          used_d = used_q - CNT_W'(1);
        end
      end
      MODE_READ: begin
        if (pos_ext >= used_ext) status_d = STATUS_BADPOS;
        else rd_d = slots_q[pos_idx];
      end
      MODE_CLEAR: begin
        used_d = '0;
      end
      default: status_d = STATUS_OK;
    endcase
  end

  // slots at and above the position move in parallel: up for insert, down for remove
  always_comb begin
    up_shift[0] = entry_q;
    for (int i = 1; i < DEPTH; i++) up_shift[i] = slots_q[i-1];
    for (int i = 0; i < DEPTH - 1; i++) dn_shift[i] = slots_q[i+1];
    dn_shift[DEPTH-1] = slots_q[DEPTH-1];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (ins_ok && CMP_W'(i) == pos_ext) slots_q[i] <= entry_q;
        else if (ins_ok && CMP_W'(i) > pos_ext) slots_q[i] <= up_shift[i];
        else if (rem_ok && CMP_W'(i) >= pos_ext) slots_q[i] <= dn_shift[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else if (cmd_i.exec) begin
      used_q <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q  <= mode_e'(mode_i);
      pos_q   <= position_i;
      entry_q <= entry_wide[ENTRY_WIDTH-1:0];
    end
  end

  assign rd_wide  = 64'(rd_d);
  assign cnt_wide = CMP_W'(used_d);

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      status_q <= status_d;
      read_q   <= rd_wide[31:0];
      count_q  <= cnt_wide[4:0];
      empty_q  <= (used_d == '0);
      full_q   <= (used_d == CNT_W'(DEPTH));
    end
  end

  assign status_o     = status_q;
  assign read_entry_o = read_q;
  assign count_o      = count_q;
  assign empty_res_o  = empty_q;
  assign full_res_o   = full_q;

endmodule

// ===== rtl/positional_list_engine.sv =====
`timescale 1ns / 1ps

// positional_list_engine: ordered list of up to DEPTH entries, head at zero.
// input channel: in_valid_i / in_stall_o carrying mode_i, position_i and
// entry_i; a request is taken at a rising edge with valid high, stall low.
// modes: insert at a position, remove at a position, read, clear.
// output channel: out_valid_o / out_stall_i carrying status_o, read_entry_o,
// count_o, empty_res_o, full_res_o; one result per request.
// the request is registered when taken; in the execute step that follows,
// the slots at and above the position shift in parallel and the result
// register loads. the next request is taken in the same cycle its
// predecessor's result is taken.
// one request is in flight at a time: while the receiver stalls the result
// holds and in_stall_o stays high.
// reset clears the entry count and the controller; slot contents are not
// cleared and only slots below the count are ever read.

module positional_list_engine import ple_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [4:0]  position_i,
  input  logic [31:0] entry_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [31:0] read_entry_o,
  output logic [4:0]  count_o,
  output logic        empty_res_o,
  output logic        full_res_o
);

  ctrl_cmd_t cmd;

  ple_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  ple_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .mode_i       (mode_i),
    .position_i   (position_i),
    .entry_i      (entry_i),
    .status_o     (status_o),
    .read_entry_o (read_entry_o),
    .count_o      (count_o),
    .empty_res_o  (empty_res_o),
    .full_res_o   (full_res_o)
  );

  a_busy_while_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> in_stall_o)
    else $error("request taken while a result is still pending");

  a_result_after_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |-> ##1 !out_valid_o ##1 out_valid_o)
    else $error("result not delivered two cycles after request");

  a_exec_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.exec |=> (out_valid_o && !cmd.exec))
    else $error("execute step not followed by result");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(empty_res_o && full_res_o))
    else $error("list reported both empty and full");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == STATUS_FULL) |-> full_res_o)
    else $error("list full status without full flag");

endmodule
